/* design/clns_pkg.sv */
// shared types, constants and tables of the character display nibble sequencer
`default_nettype none
package clns_pkg;

	localparam int MAX_COLUMNS = 31;

	localparam int CMD_W   = 2;
	localparam int VALUE_W = 8;
	localparam int NIB_W   = 4;
	localparam int WAIT_W  = 13;
	localparam int COLS_W  = 5;
	localparam int LINES_W = 3;
	localparam int COL_W   = 6;
	localparam int LINE_W  = 2;
	localparam int IDX_W   = 3;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register selects, paddr bit 2
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_LINES   = 1'b1;

	localparam logic [COLS_W-1:0]  COLUMNS_RESET = 5'd16;
	localparam logic [LINES_W-1:0] LINES_RESET   = 3'd2;
	localparam logic [LINES_W-1:0] LINES_MIN     = 3'd1;
	localparam logic [LINES_W-1:0] LINES_MAX     = 3'd4;

	localparam logic [WAIT_W-1:0]  WAIT_SHORT_US = 13'd45;
	localparam logic [WAIT_W-1:0]  WAIT_CLEAR_US = 13'd2045;
	localparam logic [VALUE_W-1:0] CLEAR_LIMIT   = 8'h04;
	localparam logic [VALUE_W-1:0] SPACE_CHAR    = 8'h20;
	localparam logic [VALUE_W-1:0] NEWLINE_CHAR  = 8'h0A;
	localparam logic [VALUE_W-1:0] SET_ADDR      = 8'h80;
	localparam logic [COL_W-1:0]   COL_MAX       = 6'd63;

	localparam logic [IDX_W-1:0] WAKE_LAST = 3'd3;
	localparam logic [IDX_W-1:0] INIT_LAST = 3'd4;

	localparam logic [NIB_W-1:0]   WAKE_NIB  [0:3] = '{4'h3, 4'h3, 4'h3, 4'h2};
	localparam logic [WAIT_W-1:0]  WAKE_WAIT [0:3] = '{13'd5045, 13'd245, 13'd45, 13'd45};
	localparam logic [VALUE_W-1:0] INIT_BYTE [0:4] = '{8'h28, 8'h08, 8'h01, 8'h0C, 8'h80};
	localparam logic [VALUE_W-1:0] LINE_ADDR [0:3] = '{8'h00, 8'h40, 8'h14, 8'h54};

	typedef enum logic [CMD_W-1:0] {
		CMD_INSTR  = 2'd0,
		CMD_CHAR   = 2'd1,
		CMD_INIT   = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_code_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WAKE,
		S_INIT,
		S_PAD,
		S_HI,
		S_LO
	} state_t;

	typedef enum logic [2:0] {
		BOP_NONE,
		BOP_INSTR,
		BOP_CHAR,
		BOP_SPACE,
		BOP_ADDR,
		BOP_INIT
	} byte_op_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_HI,
		EMIT_LO,
		EMIT_WAKE
	} emit_t;

	typedef struct packed {
		byte_op_t byte_op;
		emit_t    emit;
		logic     emit_last;
		logic     col_inc;
		logic     cursor_clr;
		logic     pad_load;
		logic     pad_dec;
		logic     idx_clr;
		logic     idx_inc;
	} dp_cmd_t;

	typedef struct packed {
		logic can_load;
		logic is_newline;
		logic pad_zero;
		logic wake_last;
		logic init_last;
	} dp_status_t;

endpackage
`default_nettype wire

/* design/clns_ifs.sv */
// valid/ready channel interfaces for input items and bus transfers
`default_nettype none
interface clns_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [clns_pkg::CMD_W-1:0]   command;
	logic [clns_pkg::VALUE_W-1:0] value;
	modport source (output valid, output command, output value, input ready);
	modport sink (input valid, input command, input value, output ready);
endinterface

interface clns_xfer_if;
	logic                        valid;
	logic                        ready;
	logic [clns_pkg::NIB_W-1:0]  nibble;
	logic                        reg_select;
	logic [clns_pkg::WAIT_W-1:0] wait_us;
	logic                        last;
	modport source (output valid, output nibble, output reg_select, output wait_us,
		output last, input ready);
	modport sink (input valid, input nibble, input reg_select, input wait_us,
		input last, output ready);
endinterface
`default_nettype wire

/* design/clns_ctrl.sv */
// sequencer state machine issuing datapath commands
`default_nettype none
module clns_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic [clns_pkg::CMD_W-1:0] command,
	output logic                          in_ready,
	input  wire clns_pkg::dp_status_t     status,
	output clns_pkg::dp_cmd_t             cmd
);
	import clns_pkg::*;

	state_t state_q, state_d;
	state_t ret_q, ret_d;
	logic   final_q, final_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			final_q <= final_d;
		end
	end

	// next state, return point after a byte, and the last-byte flag
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		final_d = final_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (cmd_code_t'(command))
						CMD_INSTR: begin
							state_d = S_HI;
							final_d = 1'b1;
						end
						CMD_CHAR: begin
							if (status.is_newline) begin
								state_d = S_PAD;
							end else begin
								state_d = S_HI;
								final_d = 1'b1;
							end
						end
						CMD_INIT: state_d = S_WAKE;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_WAKE: begin
				if (status.can_load && status.wake_last) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				state_d = S_HI;
				ret_d   = S_INIT;
				final_d = status.init_last;
			end
			S_PAD: begin
				state_d = S_HI;
				ret_d   = S_PAD;
				final_d = status.pad_zero;
			end
			S_HI: begin
				if (status.can_load) begin
					state_d = S_LO;
				end
			end
			S_LO: begin
				if (status.can_load) begin
					state_d = final_q ? S_IDLE : ret_q;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (cmd_code_t'(command))
						CMD_INSTR: cmd.byte_op = BOP_INSTR;
						CMD_CHAR: begin
							if (status.is_newline) begin
								cmd.pad_load = 1'b1;
							end else begin
								cmd.byte_op = BOP_CHAR;
								cmd.col_inc = 1'b1;
							end
						end
						CMD_INIT: begin
							cmd.idx_clr    = 1'b1;
							cmd.cursor_clr = 1'b1;
						end
						default: cmd.byte_op = BOP_NONE;
					endcase
				end
			end
			S_WAKE: begin
				if (status.can_load) begin
					cmd.emit    = EMIT_WAKE;
					cmd.idx_inc = !status.wake_last;
					cmd.idx_clr = status.wake_last;
				end
			end
			S_INIT: begin
				cmd.byte_op = BOP_INIT;
				cmd.idx_inc = 1'b1;
			end
			S_PAD: begin
				if (status.pad_zero) begin
					cmd.byte_op = BOP_ADDR;
				end else begin
					cmd.byte_op = BOP_SPACE;
					cmd.pad_dec = 1'b1;
				end
			end
			S_HI: begin
				if (status.can_load) begin
					cmd.emit = EMIT_HI;
				end
			end
			S_LO: begin
				if (status.can_load) begin
					cmd.emit      = EMIT_LO;
					cmd.emit_last = final_q;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

/* design/clns_dp.sv */
// cursor, byte and counter registers plus the transfer output register
`default_nettype none
module clns_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire clns_pkg::dp_cmd_t           cmd,
	output clns_pkg::dp_status_t             status,
	input  wire logic [clns_pkg::VALUE_W-1:0] value,
	input  wire logic [clns_pkg::COLS_W-1:0]  columns,
	input  wire logic [clns_pkg::LINES_W-1:0] lines,
	clns_xfer_if.source                      xfer
);
	import clns_pkg::*;

	logic [COL_W-1:0]   col_q;
	logic [LINE_W-1:0]  line_q;
	logic [COLS_W-1:0]  pad_q;
	logic [IDX_W-1:0]   idx_q;
	logic [VALUE_W-1:0] byte_q;
	logic               rs_q;
	logic               out_valid_q;
	logic [NIB_W-1:0]   out_nib_q;
	logic               out_rs_q;
	logic [WAIT_W-1:0]  out_wait_q;
	logic               out_last_q;

	logic [COLS_W-1:0]  pad_end;
	logic [COLS_W-1:0]  pad_init;
	logic [LINES_W-1:0] lines_eff;
	logic [LINES_W-1:0] line_inc;
	logic [LINE_W-1:0]  line_next;
	logic [WAIT_W-1:0]  byte_wait;

	assign pad_end  = (columns > COLS_W'(MAX_COLUMNS)) ? COLS_W'(MAX_COLUMNS) : columns;
	assign pad_init = ({1'b0, pad_end} > col_q) ?
		COLS_W'({1'b0, pad_end} - col_q) : '0;

	assign lines_eff = (lines < LINES_MIN) ? LINES_MIN :
		(lines > LINES_MAX) ? LINES_MAX : lines;
	assign line_inc  = {1'b0, line_q} + 3'd1;
	assign line_next = (line_inc >= lines_eff) ? '0 : line_inc[LINE_W-1:0];

	assign byte_wait = (!rs_q && byte_q < CLEAR_LIMIT) ? WAIT_CLEAR_US : WAIT_SHORT_US;

	assign status.can_load   = !out_valid_q || xfer.ready;
	assign status.is_newline = (value == NEWLINE_CHAR);
	assign status.pad_zero   = (pad_q == '0);
	assign status.wake_last  = (idx_q == WAKE_LAST);
	assign status.init_last  = (idx_q == INIT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			line_q      <= '0;
			pad_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cursor_clr) begin
				col_q  <= '0;
				line_q <= '0;
			end else if (cmd.byte_op == BOP_ADDR) begin
				col_q  <= '0;
				line_q <= line_next;
			end else if (cmd.col_inc && col_q != COL_MAX) begin
				col_q <= col_q + 6'd1;
			end

			if (cmd.pad_load) begin
				pad_q <= pad_init;
			end else if (cmd.pad_dec) begin
				pad_q <= pad_q - 5'd1;
			end

			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 3'd1;
			end

			if (cmd.emit != EMIT_NONE) begin
				out_valid_q <= 1'b1;
			end else if (xfer.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.byte_op)
			BOP_INSTR: begin
				byte_q <= value;
				rs_q   <= 1'b0;
			end
			BOP_CHAR: begin
				byte_q <= value;
				rs_q   <= 1'b1;
			end
			BOP_SPACE: begin
				byte_q <= SPACE_CHAR;
				rs_q   <= 1'b1;
			end
			BOP_ADDR: begin
				byte_q <= SET_ADDR | LINE_ADDR[line_next];
				rs_q   <= 1'b0;
			end
			BOP_INIT: begin
				byte_q <= INIT_BYTE[idx_q];
				rs_q   <= 1'b0;
			end
			default: begin
				byte_q <= byte_q;
				rs_q   <= rs_q;
			end
		endcase

		case (cmd.emit)
			EMIT_HI: begin
				out_nib_q  <= byte_q[7:4];
				out_rs_q   <= rs_q;
				out_wait_q <= byte_wait;
				out_last_q <= 1'b0;
			end
			EMIT_LO: begin
				out_nib_q  <= byte_q[3:0];
				out_rs_q   <= rs_q;
				out_wait_q <= byte_wait;
				out_last_q <= cmd.emit_last;
			end
			EMIT_WAKE: begin
				out_nib_q  <= WAKE_NIB[idx_q[1:0]];
				out_rs_q   <= 1'b0;
				out_wait_q <= WAKE_WAIT[idx_q[1:0]];
				out_last_q <= 1'b0;
			end
			default: begin
				out_nib_q  <= out_nib_q;
				out_rs_q   <= out_rs_q;
				out_wait_q <= out_wait_q;
				out_last_q <= out_last_q;
			end
		endcase
	end

	assign xfer.valid      = out_valid_q;
	assign xfer.nibble     = out_nib_q;
	assign xfer.reg_select = out_rs_q;
	assign xfer.wait_us    = out_wait_q;
	assign xfer.last       = out_last_q;

	// a pending transfer is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit != EMIT_NONE) |-> (!out_valid_q || xfer.ready))
		else $error("transfer register overwritten while held");

	// padding countdown never wraps below zero
	a_pad_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pad_dec |-> (pad_q != '0))
		else $error("pad count underflow");

	// init table index stays inside the set-up list
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.byte_op == BOP_INIT) |-> (idx_q <= INIT_LAST))
		else $error("init index out of range");

	// a set-address byte always leaves the cursor at column zero
	a_addr_col: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.byte_op == BOP_ADDR) |=> (col_q == '0))
		else $error("column not cleared on line change");

endmodule
`default_nettype wire

/* design/char_lcd_nibble_sequencer_unit.sv */
// top level of the character display nibble sequencer with its register port
`default_nettype none
// Turns instruction bytes, characters and an initialize request into the
// nibble transfers of a 4-bit character display bus. Each result item is one
// enable-strobed transfer: the nibble, the register-select level, the wait in
// microseconds to keep before the next transfer, and a last flag on the final
// transfer of the input item. Bytes go out high nibble first; instructions
// below 4 (clear, home) carry a 2045 us wait, other bytes 45 us.
// Initialize sends wake nibbles 3,3,3,2 and the set-up list 0x28, 0x08, 0x01,
// 0x0C, 0x80 (fourteen transfers) and homes the cursor. A newline character
// pads the row with spaces up to columns_in_use and then sets the address of
// the next line. Command code 3 is dropped without any transfer.
// One item is worked on at a time; each byte goes through a load step, a
// high-nibble step and a low-nibble step, and each wake nibble is emitted
// straight from the wake table. The single output register lets the next
// transfer be prepared while the current one waits, and a held transfer
// stalls the sequencer.
// Registers (APB, 32-bit, write in the access phase, no wait states):
// 0x0 columns_in_use (5 bits, reset 16), 0x4 lines_in_use (3 bits, reset 2).
// Write them only while the block is idle.
module char_lcd_nibble_sequencer_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [clns_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [clns_pkg::PDATA_W-1:0]  pwdata,
	output logic      [clns_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	clns_cmd_if.sink                           cmd_in,
	clns_xfer_if.source                        xfer_out
);
	import clns_pkg::*;

	logic [COLS_W-1:0]  columns_q;
	logic [LINES_W-1:0] lines_q;
	logic               wr_en;
	dp_cmd_t            dp_cmd;
	dp_status_t         dp_status;

	// register port, always ready
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
			lines_q   <= LINES_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_COLUMNS: columns_q <= pwdata[COLS_W-1:0];
				REG_LINES:   lines_q   <= pwdata[LINES_W-1:0];
				default:     columns_q <= columns_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_COLUMNS: prdata = {{(PDATA_W-COLS_W){1'b0}}, columns_q};
			REG_LINES:   prdata = {{(PDATA_W-LINES_W){1'b0}}, lines_q};
			default:     prdata = '0;
		endcase
	end

	// sequencer: takes an item when idle and steps through its transfers
	clns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_in.valid),
		.command  (cmd_in.command),
		.in_ready (cmd_in.ready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	// cursor tracking, byte selection and the transfer register
	clns_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (dp_cmd),
		.status  (dp_status),
		.value   (cmd_in.value),
		.columns (columns_q),
		.lines   (lines_q),
		.xfer    (xfer_out)
	);

endmodule
`default_nettype wire

/* sim/testbench.sv */
// self-checking testbench of the character display nibble sequencer
`default_nettype none
// Drives input items (instruction bytes, characters, initialize, and the
// dropped command code 3) through the valid/ready input channel. Every bus
// transfer that comes out is checked field by field against the transfers
// that a local predictor derives from each accepted item.
// The run starts with a short directed table: the clear/home wait boundary,
// extreme bytes, the dropped command, initialize, characters and newlines.
// Then it goes through several register settings written over the APB port
// while the block is idle. The settings include zero row and column
// counts and out-of-range row counts, each register is read back after
// its write, and each setting is followed by an initialize and a random
// mix of text, newlines and instructions. One row of text runs past the
// column counter's saturation point.
// Both channel sides insert random gaps, and some phases run without any.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 12;
	localparam int MAX_GAP       = 5;
	localparam int IDLE_SETTLE   = 20;
	localparam int END_SETTLE    = 120;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int REPORT_LIMIT  = 10;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 9;
	localparam int LONG_ROW      = 66;
	localparam int DIRECTED_ROWS = 16;

	// register byte addresses
	localparam logic [clns_pkg::PADDR_W-1:0] ADDR_COLUMNS = 3'h0;
	localparam logic [clns_pkg::PADDR_W-1:0] ADDR_LINES   = 3'h4;

	localparam logic [12:0] US_SHORT = 13'd45;
	localparam logic [12:0] US_CLEAR = 13'd2045;
	localparam logic [12:0] US_WAKE0 = 13'd5045;
	localparam logic [12:0] US_WAKE1 = 13'd245;
	localparam logic [7:0]  CHAR_SPACE   = 8'h20;
	localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0]  INSTR_SETUP  = 8'h28;
	localparam logic [7:0]  INSTR_OFF    = 8'h08;
	localparam logic [7:0]  INSTR_CLEAR  = 8'h01;
	localparam logic [7:0]  INSTR_ON     = 8'h0C;
	localparam logic [7:0]  INSTR_SETADR = 8'h80;
	localparam logic [7:0]  HOME_LIMIT   = 8'h04;
	localparam logic [3:0]  WAKE_NIB     = 4'h3;
	localparam logic [3:0]  WAKE_FINAL   = 4'h2;
	localparam logic [5:0]  COL_SAT      = 6'd63;

	typedef struct packed {
		logic [3:0]  nibble;
		logic        reg_select;
		logic [12:0] wait_us;
		logic        last;
	} bus_xfer_t;

	// directed row; typed rows carry their expected byte transfer inline
	typedef struct packed {
		clns_pkg::cmd_code_t cmd;
		logic [7:0]          value;
		logic                typed;
		logic [1:0]          n_typed;
		logic                rs_typed;
		logic [12:0]         wait_typed;
	} directed_row_t;

	localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		'{clns_pkg::CMD_INSTR,  8'h00, 1'b1, 2'd2, 1'b0, US_CLEAR},  // clear
		'{clns_pkg::CMD_INSTR,  8'h03, 1'b1, 2'd2, 1'b0, US_CLEAR},  // top of the long wait
		'{clns_pkg::CMD_INSTR,  8'h04, 1'b1, 2'd2, 1'b0, US_SHORT},  // first short wait
		'{clns_pkg::CMD_INSTR,  8'hFF, 1'b1, 2'd2, 1'b0, US_SHORT},
		'{clns_pkg::CMD_UNUSED, 8'h55, 1'b1, 2'd0, 1'b0, 13'd0},     // dropped, no transfer
		'{clns_pkg::CMD_UNUSED, 8'hAA, 1'b1, 2'd0, 1'b0, 13'd0},
		'{clns_pkg::CMD_INIT,   8'h00, 1'b0, 2'd0, 1'b0, 13'd0},
		'{clns_pkg::CMD_CHAR,   8'h41, 1'b1, 2'd2, 1'b1, US_SHORT},
		'{clns_pkg::CMD_CHAR,   8'h00, 1'b1, 2'd2, 1'b1, US_SHORT},
		'{clns_pkg::CMD_CHAR,   8'hFF, 1'b1, 2'd2, 1'b1, US_SHORT},
		'{clns_pkg::CMD_CHAR,   8'h0A, 1'b0, 2'd0, 1'b0, 13'd0},     // pad rest of row
		'{clns_pkg::CMD_CHAR,   8'h0A, 1'b0, 2'd0, 1'b0, 13'd0},     // full row, line wraps
		'{clns_pkg::CMD_CHAR,   8'h0A, 1'b0, 2'd0, 1'b0, 13'd0},
		'{clns_pkg::CMD_CHAR,   8'h5A, 1'b1, 2'd2, 1'b1, US_SHORT},
		'{clns_pkg::CMD_INIT,   8'hFF, 1'b0, 2'd0, 1'b0, 13'd0},     // homes the cursor
		'{clns_pkg::CMD_INSTR,  8'h80, 1'b1, 2'd2, 1'b0, US_SHORT}
	};

	// register settings per phase: zero, extremes and out-of-range row counts
	localparam logic [4:0] PHASE_COLS  [0:PHASES-1] = '{5'd31, 5'd1, 5'd0, 5'd31, 5'd8, 5'd5,
		5'd16, 5'd0};
	localparam logic [2:0] PHASE_LINES [0:PHASES-1] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd3, 3'd5,
		3'd2, 3'd6};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [clns_pkg::PADDR_W-1:0] paddr;
	logic [clns_pkg::PDATA_W-1:0] pwdata;
	logic [clns_pkg::PDATA_W-1:0] prdata;
	logic pready;

	clns_cmd_if  cmd_bus ();
	clns_xfer_if xfer_bus ();

	char_lcd_nibble_sequencer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cmd_in   (cmd_bus),
		.xfer_out (xfer_bus)
	);

	// predictor state and register copies
	logic [5:0] cursor_col;
	logic [1:0] cursor_row;
	logic [4:0] cols_setting;
	logic [2:0] lines_setting;

	bus_xfer_t item_xfers[$];     // transfers of the item being predicted
	bus_xfer_t awaited_xfers[$];  // transfers still owed by the block

	int errors;
	int items_sent;
	int xfers_checked;
	int settings_run;
	int cycle_count;
	bit quiet;  // phase without gaps or stalls

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// display address of the start of each row
	function automatic logic [7:0] row_base(input logic [1:0] row);
		case (row)
			2'd0: row_base = 8'h00;
			2'd1: row_base = 8'h40;
			2'd2: row_base = 8'h14;
			default: row_base = 8'h54;
		endcase
	endfunction

	function automatic void add_xfer(input logic [3:0] nib, input logic rs,
		input logic [12:0] wait_us);
		bus_xfer_t x;
		x.nibble = nib;
		x.reg_select = rs;
		x.wait_us = wait_us;
		x.last = 1'b0;
		item_xfers.push_back(x);
	endfunction

	// high nibble first
	function automatic void add_byte(input logic [7:0] b, input logic rs,
		input logic [12:0] wait_us);
		add_xfer(b[7:4], rs, wait_us);
		add_xfer(b[3:0], rs, wait_us);
	endfunction

	// clear and home need the long wait
	function automatic void add_instr(input logic [7:0] b);
		add_byte(b, 1'b0, (b < HOME_LIMIT) ? US_CLEAR : US_SHORT);
	endfunction

	// transfers caused by one accepted item, with the cursor update
	function automatic void derive_transfers(input clns_pkg::cmd_code_t code,
		input logic [7:0] v);
		int pad_end;
		int col;
		int rows;
		item_xfers.delete();
		case (code)
			clns_pkg::CMD_INSTR: begin
				add_instr(v);
			end
			clns_pkg::CMD_CHAR: begin
				if (v == CHAR_NEWLINE) begin
					// spaces from the cursor up to the padding end
					pad_end = int'(cols_setting);
					if (pad_end > clns_pkg::MAX_COLUMNS)
						pad_end = clns_pkg::MAX_COLUMNS;
					for (col = int'(cursor_col); col < pad_end; col++)
						add_byte(CHAR_SPACE, 1'b1, US_SHORT);
					// row count clamped to 1..4
					rows = int'(lines_setting);
					if (rows < 1)
						rows = 1;
					if (rows > 4)
						rows = 4;
					if (cursor_row + 1 >= rows)
						cursor_row = 2'd0;
					else
						cursor_row = cursor_row + 2'd1;
					cursor_col = 6'd0;
					add_instr(INSTR_SETADR | row_base(cursor_row));
				end else begin
					add_byte(v, 1'b1, US_SHORT);
					if (cursor_col != COL_SAT)
						cursor_col = cursor_col + 6'd1;
				end
			end
			clns_pkg::CMD_INIT: begin
				// wake nibbles, then the set-up list
				add_xfer(WAKE_NIB, 1'b0, US_WAKE0);
				add_xfer(WAKE_NIB, 1'b0, US_WAKE1);
				add_xfer(WAKE_NIB, 1'b0, US_SHORT);
				add_xfer(WAKE_FINAL, 1'b0, US_SHORT);
				add_instr(INSTR_SETUP);
				add_instr(INSTR_OFF);
				add_instr(INSTR_CLEAR);
				add_instr(INSTR_ON);
				add_instr(INSTR_SETADR);
				cursor_row = 2'd0;
				cursor_col = 6'd0;
			end
			default: begin
				// command code 3 is dropped
			end
		endcase
		if (item_xfers.size() > 0)
			item_xfers[item_xfers.size() - 1].last = 1'b1;
	endfunction

	function automatic void flag_error(input string msg);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("mismatch: %s", msg);
	endfunction

	// one item through the input channel; expectations queued on acceptance
	task automatic send_item(input clns_pkg::cmd_code_t code, input logic [7:0] v,
		input directed_row_t row);
		int gap;
		bus_xfer_t x;
		gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.command <= code;
		cmd_bus.value <= v;
		do @(posedge clk); while (cmd_bus.ready !== 1'b1);
		items_sent++;
		derive_transfers(code, v);
		// typed rows replace the predicted transfers, cursor update is kept
		if (row.typed) begin
			item_xfers.delete();
			if (row.n_typed == 2'd2) begin
				x.reg_select = row.rs_typed;
				x.wait_us = row.wait_typed;
				x.nibble = v[7:4];
				x.last = 1'b0;
				item_xfers.push_back(x);
				x.nibble = v[3:0];
				x.last = 1'b1;
				item_xfers.push_back(x);
			end
		end
		foreach (item_xfers[i])
			awaited_xfers.push_back(item_xfers[i]);
	endtask

	task automatic send_random(input clns_pkg::cmd_code_t code, input logic [7:0] v);
		directed_row_t none;
		none = '0;
		send_item(code, v, none);
	endtask

	// hold the input side until every owed transfer is out
	task automatic drain;
		cmd_bus.valid <= 1'b0;
		while (awaited_xfers.size() != 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	// write over APB, then read back
	task automatic set_register(input logic [clns_pkg::PADDR_W-1:0] addr,
		input logic [clns_pkg::PDATA_W-1:0] data, input logic [clns_pkg::PDATA_W-1:0] mask);
		logic [clns_pkg::PDATA_W-1:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if ((rd & mask) !== (data & mask))
			flag_error($sformatf("register 0x%0h read back %0h, written %0h", addr, rd, data));
	endtask

	task automatic apply_setting(input logic [4:0] cols, input logic [2:0] lines);
		set_register(ADDR_COLUMNS, {27'd0, cols}, 32'h1F);
		cols_setting = cols;
		set_register(ADDR_LINES, {29'd0, lines}, 32'h7);
		lines_setting = lines;
		settings_run++;
	endtask

	// random item, mostly text and newlines
	task automatic send_mixed;
		int pick;
		logic [7:0] v;
		pick = $urandom_range(0, 99);
		v = 8'($urandom_range(0, 255));
		if (pick < 45)
			send_random(clns_pkg::CMD_CHAR, v);
		else if (pick < 62)
			send_random(clns_pkg::CMD_CHAR, CHAR_NEWLINE);
		else if (pick < 80) begin
			if ($urandom_range(0, 3) == 0)
				v = 8'($urandom_range(0, 3));
			send_random(clns_pkg::CMD_INSTR, v);
		end else if (pick < 86)
			send_random(clns_pkg::CMD_INIT, v);
		else if (pick < 92)
			send_random(clns_pkg::CMD_UNUSED, v);
		else
			send_random(clns_pkg::CMD_INSTR, INSTR_SETADR | v);
	endtask

	// bus side: random stall before taking each transfer
	initial begin
		int stall;
		forever begin
			stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				xfer_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			xfer_bus.ready <= 1'b1;
			do @(posedge clk); while (xfer_bus.valid !== 1'b1);
		end
	end

	// compare each transfer taken with the oldest owed one
	always @(posedge clk) begin
		bus_xfer_t seen;
		bus_xfer_t owed;
		if (arst_n === 1'b1 && xfer_bus.valid === 1'b1 && xfer_bus.ready === 1'b1) begin
			seen.nibble = xfer_bus.nibble;
			seen.reg_select = xfer_bus.reg_select;
			seen.wait_us = xfer_bus.wait_us;
			seen.last = xfer_bus.last;
			if (awaited_xfers.size() == 0)
				flag_error($sformatf("transfer nib %h rs %b wait %0d last %b with none owed",
					seen.nibble, seen.reg_select, seen.wait_us, seen.last));
			else begin
				owed = awaited_xfers.pop_front();
				if (seen.nibble !== owed.nibble || seen.reg_select !== owed.reg_select ||
					seen.wait_us !== owed.wait_us || seen.last !== owed.last)
					flag_error($sformatf(
						"transfer %0d: want nib %h rs %b wait %0d last %b, got %h %b %0d %b",
						xfers_checked, owed.nibble, owed.reg_select, owed.wait_us, owed.last,
						seen.nibble, seen.reg_select, seen.wait_us, seen.last));
			end
			xfers_checked++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.command <= clns_pkg::CMD_INSTR;
		cmd_bus.value <= '0;
		cursor_col = 6'd0;
		cursor_row = 2'd0;
		cols_setting = 5'd16;
		lines_setting = 3'd2;
		quiet = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset settings
		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_item(DIRECTED[r].cmd, DIRECTED[r].value, DIRECTED[r]);
		drain();

		// random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			quiet = (p == 2 || p == 5);
			if (p == PHASES - 1)
				apply_setting(5'($urandom_range(1, 31)), 3'($urandom_range(1, 4)));
			else
				apply_setting(PHASE_COLS[p], PHASE_LINES[p]);
			send_random(clns_pkg::CMD_INIT, 8'($urandom_range(0, 255)));
			// one row long enough to saturate the column counter
			if (p == 0) begin
				for (int k = 0; k < LONG_ROW; k++)
					send_random(clns_pkg::CMD_CHAR, 8'($urandom_range(8'h21, 8'h7E)));
				send_random(clns_pkg::CMD_CHAR, CHAR_NEWLINE);
			end
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_mixed();
			drain();
		end
		quiet = 1'b0;

		repeat (END_SETTLE) @(posedge clk);
		$display("run covered %0d items and %0d bus transfers under %0d register settings",
			items_sent, xfers_checked, settings_run);
		$display("failures counted: %0d", errors);
		if (errors == 0 && awaited_xfers.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
